FILE: rtl/dsmf_pkg.sv
// Shared types, constants and CRC-16/Modbus helper for the setpoint framer.
// No dependencies.
package dsmf_pkg;

    localparam int FrameLen = 11;
    localparam int HdrLen   = 7;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    // Q8.8 limits, 4 mA and 20 mA
    localparam logic signed [15:0] CurMin = 16'sd1024;
    localparam logic signed [15:0] CurMax = 16'sd5120;

    // header bytes in send order, element 0 first
    localparam logic [HdrLen-1:0][7:0] FrameHdr =
        {8'h02, 8'h01, 8'h00, 8'h05, 8'h00, 8'h10, 8'h01};

    typedef struct packed {
        logic [11:0] code;
        logic [15:0] crc;
    } t_frame;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_hdr();
        logic [15:0] c;
        c = CrcInit;
        for (int k = 0; k < HdrLen; k++) begin
            c = crc_byte(c, FrameHdr[k]);
        end
        return c;
    endfunction

    // CRC state after the fixed header, folded at elaboration
    localparam logic [15:0] CrcAfterHdr = crc_hdr();

endpackage

FILE: rtl/dsmf_code.sv
// Two pipeline stages: clamp and offset of the Q8.8 current, then the DAC code.
// Depends on dsmf_pkg.
module dsmf_code
    import dsmf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_target_current,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [11:0]        o_code
);

    logic        r_a_v, r_b_v;
    logic [12:0] r_d;
    logic [11:0] r_code;
    logic [12:0] n_d;
    logic [12:0] n_dm1;
    logic [15:0] n_diff;
    logic        adv_a, adv_b;

    assign adv_b   = !r_b_v || i_ready;
    assign adv_a   = !r_a_v || adv_b;
    assign o_ready = adv_a;

    always_comb begin
        n_diff = 16'(i_target_current - CurMin);
        priority if (i_target_current < CurMin) begin
            n_d = 13'd0;
        end else if (i_target_current > CurMax) begin
            n_d = 13'd4096;
        end else begin
            n_d = n_diff[12:0];
        end
    end

    // floor(d*4095/4096) is d-1 for d>0, 0 for d=0
    assign n_dm1 = r_d - 13'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (adv_a) r_a_v <= i_valid;
            if (adv_b) r_b_v <= r_a_v;
        end
        if (adv_a && i_valid) r_d <= n_d;
        if (adv_b && r_a_v) r_code <= (r_d == 13'd0) ? 12'd0 : n_dm1[11:0];
    end

    assign o_valid = r_b_v;
    assign o_code  = r_code;

endmodule

FILE: rtl/dsmf_crc.sv
// Two pipeline stages of CRC-16/Modbus over the code high byte, then low byte.
// Depends on dsmf_pkg.
module dsmf_crc
    import dsmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_code,
    output logic        o_valid,
    input  logic        i_ready,
    output t_frame      o_frame
);

    logic        r_c_v, r_d_v;
    logic [11:0] r_c_code;
    logic [15:0] r_c_crc;
    t_frame      r_frame;
    logic        adv_c, adv_d;

    assign adv_d   = !r_d_v || i_ready;
    assign adv_c   = !r_c_v || adv_d;
    assign o_ready = adv_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (adv_c) r_c_v <= i_valid;
            if (adv_d) r_d_v <= r_c_v;
        end
        if (adv_c && i_valid) begin
            r_c_code <= i_code;
            r_c_crc  <= crc_byte(CrcAfterHdr, {4'h0, i_code[11:8]});
        end
        if (adv_d && r_c_v) begin
            r_frame.code <= r_c_code;
            r_frame.crc  <= crc_byte(r_c_crc, r_c_code[7:0]);
        end
    end

    assign o_valid = r_d_v;
    assign o_frame = r_frame;

endmodule

FILE: rtl/dsmf_tx.sv
// Output stage: holds one frame and sends its eleven bytes, one per transaction.
// Depends on dsmf_pkg.
module dsmf_tx
    import dsmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_frame      i_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    output logic [11:0] o_dac_code
);

    localparam int CntW = $clog2(FrameLen);
    localparam logic [CntW-1:0] LastIdx = CntW'(FrameLen - 1);
    localparam logic [CntW-1:0] IdxCodeHi = CntW'(HdrLen);
    localparam logic [CntW-1:0] IdxCodeLo = CntW'(HdrLen + 1);
    localparam logic [CntW-1:0] IdxCrcLo  = CntW'(HdrLen + 2);

    logic            r_v;
    logic [CntW-1:0] r_cnt;
    t_frame          r_frame;
    logic            last;
    logic            load;

    assign last    = (r_cnt == LastIdx);
    assign o_ready = !r_v || (i_ready && last);
    assign load    = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_cnt <= '0;
        end else if (o_ready) begin
            r_v   <= i_valid;
            r_cnt <= '0;
        end else if (i_ready) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (load) r_frame <= i_frame;
    end

    always_comb begin
        if (r_cnt < CntW'(HdrLen)) begin
            o_frame_byte = FrameHdr[r_cnt[$clog2(HdrLen)-1:0]];
        end else if (r_cnt == IdxCodeHi) begin
            o_frame_byte = {4'h0, r_frame.code[11:8]};
        end else if (r_cnt == IdxCodeLo) begin
            o_frame_byte = r_frame.code[7:0];
        end else if (r_cnt == IdxCrcLo) begin
            o_frame_byte = r_frame.crc[7:0];
        end else begin
            o_frame_byte = r_frame.crc[15:8];
        end
    end

    assign o_valid     = r_v;
    assign o_last_byte = last;
    assign o_dac_code  = r_frame.code;

endmodule

FILE: rtl/dac_setpoint_modbus_framer_core.sv
// Channel  | Handshake         | Payload
// input    | i_valid / o_ready | i_target_current (s16, Q8.8 mA)
// output   | o_valid / i_ready | o_frame_byte, o_last_byte, o_dac_code
//
// Five register stages: clamp, code, CRC high byte, CRC low byte, byte sender.
// Each setpoint gives 11 byte transactions, and the sender takes the next frame only
// as the last byte of the current one is accepted, so it sets the sustained rate.
// Up to four further setpoints queue in the pipeline while a frame goes out.
// Synchronous active-low reset clears all valid bits; stalls lose nothing.
// Top level of the setpoint framer; depends on dsmf_pkg, dsmf_code, dsmf_crc, dsmf_tx.
module dac_setpoint_modbus_framer_core
    import dsmf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_target_current,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_frame_byte,
    output logic               o_last_byte,
    output logic [11:0]        o_dac_code
);

    logic        code_v, code_rdy;
    logic [11:0] code;
    logic        crc_v, crc_rdy;
    t_frame      frame;

    dsmf_code u_code (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_target_current (i_target_current),
        .o_valid          (code_v),
        .i_ready          (code_rdy),
        .o_code           (code)
    );

    dsmf_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (code_v),
        .o_ready (code_rdy),
        .i_code  (code),
        .o_valid (crc_v),
        .i_ready (crc_rdy),
        .o_frame (frame)
    );

    dsmf_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (crc_v),
        .o_ready      (crc_rdy),
        .i_frame      (frame),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte),
        .o_dac_code   (o_dac_code)
    );

endmodule

FILE: rtl/dsmf_checker.sv
// Port-level checks on the setpoint framer, bound to the top level.
// Depends on dsmf_pkg and dac_setpoint_modbus_framer_core.
module dsmf_checker
    import dsmf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_frame_byte,
    input logic        o_last_byte,
    input logic [11:0] o_dac_code
);

    // stalled byte holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_byte))
        else $error("stalled byte changed");

    // a frame is sent without gaps
    a_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_byte |=> o_valid)
        else $error("gap inside frame");

    // code fixed for the whole frame
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_byte |=> $stable(o_dac_code))
        else $error("code changed within frame");

    // frame after a last byte opens with the slave address
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid && i_ready && o_last_byte)
            |-> o_frame_byte == FrameHdr[0] && !o_last_byte)
        else $error("frame does not start with header");

    // second byte of a frame is never the last
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid && i_ready && o_last_byte)
            |=> !o_last_byte)
        else $error("frame too short");

endmodule

bind dac_setpoint_modbus_framer_core dsmf_checker u_dsmf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_frame_byte (o_frame_byte),
    .o_last_byte  (o_last_byte),
    .o_dac_code   (o_dac_code)
);
